// File: hw/rtl/sbq_pkg.sv
package sbq_pkg;

  localparam int COEF_BITS     = 32;
  localparam int COEF_EXT_BITS = COEF_BITS + 1;
  localparam int STATE_BITS    = 56;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_A2 = 3'd4;

  typedef logic [COEF_BITS-1:0]     coef_t;
  typedef logic [COEF_EXT_BITS-1:0] coef_ext_t;
  typedef logic [STATE_BITS-1:0]    state_t;

  // control of one serial multiply-accumulate unit
  typedef struct packed {
    logic load;
    logic start;
    logic step;
  } mac_ctl_t;

endpackage

// File: hw/rtl/sbq_in_if.sv
interface sbq_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic                          channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink (input valid, input channel, input sample_in, output ready);
endinterface

// File: hw/rtl/sbq_out_if.sv
interface sbq_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic                          channel_out;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output channel_out, output sample_out, input ready);
  modport sink (input valid, input channel_out, input sample_out, output ready);
endinterface

// File: hw/rtl/stereo_biquad_iir_filter.sv
// Stereo biquad filter, transposed direct form II, shared coefficients.
// Input channel in_i carries one word per sample: a channel bit and a signed
// sample. Output channel out_o returns one filtered, saturated word per input
// word with the channel bit echoed, in order of arrival.
// Coefficients b0, b1, b2, a1, a2 (signed, COEF_FRAC_BITS fraction bits) are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must do so only
// while the block is idle, which the block itself does not enforce; writes to
// indexes beyond a2 are dropped. Arithmetic is digit-serial: three
// multiply-accumulate units take the multiplier two bits per cycle and run over a
// W-bit result word, W = 58 at the default sizes. The first pass forms the output,
// the second the delays. A word is taken only while the block is idle, so the next
// word waits until the previous one has passed through both serial passes and been
// written back.
// Reset clears the delay state of both channels, loads b0 = 1.0 and the other
// coefficients to zero, and empties the output register.
// A finished word waits in the output register while the receiver stalls; the
// next input word is still taken and worked on, and only its final write-back
// waits until the output register is free.
module stereo_biquad_iir_filter #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28,
  parameter int CHANNELS       = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sbq_pkg::REG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [sbq_pkg::COEF_BITS-1:0]        cfg_wdata_i,
  sbq_in_if.sink                               in_i,
  sbq_out_if.source                            out_o
);

  localparam int SB     = SAMPLE_BITS;
  localparam int STB    = sbq_pkg::STATE_BITS;
  localparam int CEW    = sbq_pkg::COEF_EXT_BITS;
  localparam int W_RAW  = (SB + 31 > STB) ? SB + 33 : STB + 2;
  localparam int W      = W_RAW + (W_RAW % 2);
  localparam int STEPS  = W / 2;
  localparam int CNT_W  = $clog2(STEPS);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RND_POS = COEF_FRAC_BITS - 1;
  localparam int YHI    = COEF_FRAC_BITS + SB - 1;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);
  localparam logic [CNT_W-1:0] RND_STEP  = CNT_W'(RND_POS / 2);
  localparam logic [1:0]       RND_DIG   = 2'(1 << (RND_POS % 2));
  localparam sbq_pkg::coef_t   B0_RST    = sbq_pkg::coef_t'(1 << COEF_FRAC_BITS);
  localparam logic [SB-1:0]    SMAX      = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]    SMIN      = {1'b1, {(SB-1){1'b0}}};
  localparam sbq_pkg::state_t  ST_MAX    = {1'b0, {(STB-1){1'b1}}};
  localparam sbq_pkg::state_t  ST_MIN    = {1'b1, {(STB-1){1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FWD  = 3'd1;
  localparam logic [2:0] ST_MID  = 3'd2;
  localparam logic [2:0] ST_FBK  = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_vld_q, out_vld_d;
  sbq_pkg::coef_t   b0_q, b0_d, b1_q, b1_d, b2_q, b2_d, a1_q, a1_d, a2_q, a2_d;
  sbq_pkg::state_t  s0_q [CHANNELS];
  sbq_pkg::state_t  s1_q [CHANNELS];

  logic [SB-1:0]    m_q, m_d;
  logic [SB-1:0]    y_q, y_d;
  logic             ch_q, ch_d;
  logic             out_ch_q, out_ch_d;
  logic [SB-1:0]    out_smp_q, out_smp_d;

  logic             in_acc, out_free, wb_fire;
  logic [CH_W-1:0]  in_idx, wb_idx;
  sbq_pkg::mac_ctl_t ctl_a, ctl_bc;
  sbq_pkg::coef_ext_t coef_a, coef_b, coef_c;
  logic [1:0]       rdig_a;
  logic [W-1:0]     load_a, load_b, acc_a, acc_b, acc_c;
  logic             y_fit, s0_fit, s1_fit;
  logic [SB-1:0]    y_val;
  sbq_pkg::state_t  s0_new, s1_new;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && (state_q == ST_IDLE);
  assign out_free   = !out_vld_q || out_o.ready;
  assign wb_fire    = (state_q == ST_WB) && out_free;

  // channels past the last one share the state of the last one
  assign in_idx = (CHANNELS > 1) ? CH_W'(in_i.channel) : '0;
  assign wb_idx = (CHANNELS > 1) ? CH_W'(ch_q) : '0;

  assign ctl_a.load   = in_acc;
  assign ctl_a.start  = in_acc;
  assign ctl_a.step   = (state_q == ST_FWD);
  assign ctl_bc.load  = in_acc;
  assign ctl_bc.start = in_acc || (state_q == ST_MID);
  assign ctl_bc.step  = (state_q == ST_FWD) || (state_q == ST_FBK);

  assign coef_a = {b0_q[sbq_pkg::COEF_BITS-1], b0_q};
  assign coef_b = (state_q == ST_IDLE) ? {b1_q[sbq_pkg::COEF_BITS-1], b1_q}
                                       : '0 - {a1_q[sbq_pkg::COEF_BITS-1], a1_q};
  assign coef_c = (state_q == ST_IDLE) ? {b2_q[sbq_pkg::COEF_BITS-1], b2_q}
                                       : '0 - {a2_q[sbq_pkg::COEF_BITS-1], a2_q};

  // half-lsb rounding constant folded into the output pass
  assign rdig_a = (state_q == ST_FWD && cnt_q == RND_STEP) ? RND_DIG : 2'b00;

  assign load_a = {{(W-STB){s0_q[in_idx][STB-1]}}, s0_q[in_idx]};
  assign load_b = {{(W-STB){s1_q[in_idx][STB-1]}}, s1_q[in_idx]};

  sbq_mac #(.W(W), .CW(CEW)) u_mac_a (
    .clk_i  (clk_i),
    .ctl_i  (ctl_a),
    .coef_i (coef_a),
    .mdig_i (m_q[1:0]),
    .rdig_i (rdig_a),
    .load_i (load_a),
    .acc_o  (acc_a)
  );

  sbq_mac #(.W(W), .CW(CEW)) u_mac_b (
    .clk_i  (clk_i),
    .ctl_i  (ctl_bc),
    .coef_i (coef_b),
    .mdig_i (m_q[1:0]),
    .rdig_i (2'b00),
    .load_i (load_b),
    .acc_o  (acc_b)
  );

  sbq_mac #(.W(W), .CW(CEW)) u_mac_c (
    .clk_i  (clk_i),
    .ctl_i  (ctl_bc),
    .coef_i (coef_c),
    .mdig_i (m_q[1:0]),
    .rdig_i (2'b00),
    .load_i ('0),
    .acc_o  (acc_c)
  );

  // saturation of the rounded output and of the new delays
  assign y_fit  = (&acc_a[W-1:YHI]) || !(|acc_a[W-1:YHI]);
  assign y_val  = y_fit ? acc_a[YHI:COEF_FRAC_BITS] : (acc_a[W-1] ? SMIN : SMAX);
  assign s0_fit = (&acc_b[W-1:STB-1]) || !(|acc_b[W-1:STB-1]);
  assign s1_fit = (&acc_c[W-1:STB-1]) || !(|acc_c[W-1:STB-1]);
  assign s0_new = s0_fit ? acc_b[STB-1:0] : (acc_b[W-1] ? ST_MIN : ST_MAX);
  assign s1_new = s1_fit ? acc_c[STB-1:0] : (acc_c[W-1] ? ST_MIN : ST_MAX);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q;
    m_d       = m_q;
    y_d       = y_q;
    ch_d      = ch_q;
    out_ch_d  = out_ch_q;
    out_smp_d = out_smp_q;
    b0_d      = b0_q;
    b1_d      = b1_q;
    b2_d      = b2_q;
    a1_d      = a1_q;
    a2_d      = a2_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        sbq_pkg::REG_B0: b0_d = cfg_wdata_i;
        sbq_pkg::REG_B1: b1_d = cfg_wdata_i;
        sbq_pkg::REG_B2: b2_d = cfg_wdata_i;
        sbq_pkg::REG_A1: a1_d = cfg_wdata_i;
        sbq_pkg::REG_A2: a2_d = cfg_wdata_i;
        default:         b0_d = b0_q;
      endcase
    end

    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          m_d     = in_i.sample_in;
          ch_d    = in_i.channel;
          cnt_d   = '0;
          state_d = ST_FWD;
        end
      end
      ST_FWD: begin
        m_d   = {{2{m_q[SB-1]}}, m_q[SB-1:2]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        m_d     = y_val;
        y_d     = y_val;
        cnt_d   = '0;
        state_d = ST_FBK;
      end
      ST_FBK: begin
        m_d   = {{2{m_q[SB-1]}}, m_q[SB-1:2]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_ch_d  = ch_q;
          out_smp_d = y_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      b0_q      <= B0_RST;
      b1_q      <= '0;
      b2_q      <= '0;
      a1_q      <= '0;
      a2_q      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        s0_q[i] <= '0;
        s1_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      b0_q      <= b0_d;
      b1_q      <= b1_d;
      b2_q      <= b2_d;
      a1_q      <= a1_d;
      a2_q      <= a2_d;
      if (wb_fire) begin
        s0_q[wb_idx] <= s0_new;
        s1_q[wb_idx] <= s1_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q       <= m_d;
    y_q       <= y_d;
    ch_q      <= ch_d;
    out_ch_q  <= out_ch_d;
    out_smp_q <= out_smp_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.sample_out  = out_smp_q;

endmodule

// File: hw/rtl/sbq_mac.sv
module sbq_mac #(
  parameter int W  = 58,
  parameter int CW = 33
) (
  input  logic             clk_i,
  input  sbq_pkg::mac_ctl_t ctl_i,
  input  logic [CW-1:0]    coef_i,
  input  logic [1:0]       mdig_i,
  input  logic [1:0]       rdig_i,
  input  logic [W-1:0]     load_i,
  output logic [W-1:0]     acc_o
);

  localparam int PW = CW + 2;
  localparam int SW = CW + 4;

  logic [CW-1:0] coef_q, coef_d;
  logic [PW-1:0] p_q, p_d;
  logic [W-1:0]  sr_q, sr_d;
  logic [SW-1:0] c_ext, pp0, pp1, sum;

  assign c_ext = {{(SW-CW){coef_q[CW-1]}}, coef_q};
  assign pp0   = mdig_i[0] ? c_ext : '0;
  assign pp1   = mdig_i[1] ? {c_ext[SW-2:0], 1'b0} : '0;
  // radix-4 partial product plus the addend digit leaving the bottom of the shift register
  assign sum   = {{(SW-PW){p_q[PW-1]}}, p_q} + pp0 + pp1
               + {{(SW-2){1'b0}}, sr_q[1:0]} + {{(SW-2){1'b0}}, rdig_i};

  always_comb begin
    coef_d = coef_q;
    p_d    = p_q;
    sr_d   = sr_q;
    if (ctl_i.step) begin
      p_d  = sum[SW-1:2];
      sr_d = {sum[1:0], sr_q[W-1:2]};
    end
    if (ctl_i.start) begin
      p_d    = '0;
      coef_d = coef_i;
    end
    if (ctl_i.load) begin
      sr_d = load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
    p_q    <= p_d;
    sr_q   <= sr_d;
  end

  assign acc_o = sr_q;

endmodule

// File: hw/rtl/sbq_checker.sv
module sbq_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic                   out_channel_i,
  input logic [SAMPLE_BITS-1:0] out_sample_i
);

  // output word held while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sample_i) && $stable(out_channel_i))
    else $error("output word changed while stalled");

  // one word in flight at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a word is in flight");

  // a new result only appears at the end of the serial passes
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result produced without a word in flight");

endmodule

bind stereo_biquad_iir_filter sbq_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sbq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_channel_i (out_o.channel_out),
  .out_sample_i  (out_o.sample_out)
);
